>>> rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ilt_pkg.sv
// Package for the INI line tokenizer: item types, parse phases, codes,
// controller states and character class functions. No dependencies.
package ilt_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
    logic       start_file;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [2:0] error_code;
    logic       last;
  } tok_item_t;

  typedef enum logic [2:0] {
    PH_NAME_START = 3'd0,
    PH_IN_NAME    = 3'd1,
    PH_EXPECT_EQ  = 3'd2,
    PH_VAL_START  = 3'd3,
    PH_VAL_PLAIN  = 3'd4,
    PH_VAL_QUOTED = 3'd5,
    PH_LINE_DONE  = 3'd6,
    PH_ERROR      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH_READ,
    ST_FLUSH_PUT,
    ST_FINAL
  } ctrl_state_t;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_BAD_NAME_START = 3'd0;
  localparam logic [2:0] ERR_NO_VALUE       = 3'd1;
  localparam logic [2:0] ERR_BAD_NAME_CHAR  = 3'd2;
  localparam logic [2:0] ERR_NO_EQUALS      = 3'd3;
  localparam logic [2:0] ERR_OPEN_QUOTE     = 3'd4;
  localparam logic [2:0] ERR_WS_OVERFLOW    = 3'd5;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic commit;
    logic load_final;
    logic flush_start;
    logic flush_put;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_flush;
    logic has_result;
    logic out_free;
    logic flush_done;
  } dp_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

endpackage

>>> rtl/core/ini_line_tokenizer.sv
// INI line tokenizer: splits a byte stream of INI lines into name, value,
// entry-end and error items. Uses ilt_pkg, ilt_ctrl and ilt_dp.
//
// Input channel byte_*: one text byte per item, or an end-of-line or
// start-of-file mark. Output channel tok_*: result items, each with last
// set on the final result caused by one input item. Both channels move
// an item at a clock edge where valid is high and stall is low.
// Timing: an input item is evaluated in the cycle after it is accepted,
// and no new item is taken before the last one is done; its result
// enters the output register at the end of that evaluation cycle when
// the register is free and no held whitespace goes out first. A value byte that
// follows held whitespace first releases each held byte (a memory read,
// then an output load) and then the byte itself. A stall on the output
// holds the register and the controller; the input side is stalled until
// the last result of the pending item has entered the output register.
// Reset (synchronous, active high) empties the output register and
// returns the parser to the start of a line; the whitespace buffer needs
// no clearing since entries are only read after being written.
module ini_line_tokenizer
  import ilt_pkg::*;
#(
  parameter int HOLD_DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_item_t  tok_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  ilt_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .byte_item (byte_item),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/core/ilt_ctrl.sv
// Controller of the INI line tokenizer: sequences accept, evaluate,
// release of held whitespace and the final result. Uses ilt_pkg.
module ilt_ctrl
  import ilt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (byte_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (stat.need_flush) state_next = ST_FLUSH_READ;
        else if (!stat.has_result || stat.out_free) state_next = ST_IDLE;
        else state_next = ST_EVAL;
      end
      ST_FLUSH_READ: begin
        state_next = ST_FLUSH_PUT;
      end
      ST_FLUSH_PUT: begin
        if (stat.out_free) state_next = stat.flush_done ? ST_FINAL : ST_FLUSH_READ;
      end
      ST_FINAL: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    byte_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        byte_stall    = 1'b0;
        cmd.load_item = byte_valid;
      end
      ST_EVAL: begin
        cmd.flush_start = stat.need_flush;
        // An item with no result commits at once; one with a result waits
        // for the output register.
        cmd.commit      = !stat.need_flush && (!stat.has_result || stat.out_free);
        cmd.load_final  = !stat.need_flush && stat.has_result && stat.out_free;
      end
      ST_FLUSH_READ: begin
        cmd = '0;
      end
      ST_FLUSH_PUT: begin
        cmd.flush_put = stat.out_free;
      end
      ST_FINAL: begin
        cmd.commit     = stat.out_free;
        cmd.load_final = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/ilt_dp.sv
// Datapath of the INI line tokenizer: item register, parse state, held
// whitespace memory and output register. Uses ilt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ilt_dp
  import ilt_pkg::*;
#(
  parameter int HOLD_DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst,
  input  byte_item_t byte_item,
  output logic       tok_valid,
  input  logic       tok_stall,
  output tok_item_t  tok_item,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat
);

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  byte_item_t       item;
  phase_t           phase;
  logic [7:0]       quote_byte;
  logic             escape_pending;
  logic             name_seen;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] flush_idx;
  logic [7:0]       held_space [HOLD_DEPTH];
  logic [7:0]       held_q;

  phase_t           phase_next;
  logic [7:0]       quote_byte_next;
  logic             escape_pending_next;
  logic             name_seen_next;
  logic [CNT_W-1:0] held_count_next;
  logic             held_we;
  logic             res_valid;
  logic [1:0]       res_kind;
  logic [7:0]       res_char;
  logic [2:0]       res_err;
  logic             need_flush;
  logic             out_free;
  logic [7:0]       c;

  assign c = item.ch;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= byte_item;
  end

  // Next state and the single result for the registered item.
  always_comb begin
    phase_next          = phase;
    quote_byte_next     = quote_byte;
    escape_pending_next = escape_pending;
    name_seen_next      = name_seen;
    held_count_next     = held_count;
    held_we             = 1'b0;
    res_valid           = 1'b0;
    res_kind            = KIND_NAME;
    res_char            = '0;
    res_err             = '0;
    need_flush          = 1'b0;

    priority if (item.start_file) begin
      phase_next          = PH_NAME_START;
      quote_byte_next     = '0;
      escape_pending_next = 1'b0;
      name_seen_next      = 1'b0;
      held_count_next     = '0;
    end else if (phase == PH_ERROR) begin
      phase_next = PH_ERROR;
    end else if (item.end_of_line || c == CH_NUL) begin
      unique case (phase)
        PH_NAME_START: phase_next = PH_LINE_DONE;
        PH_IN_NAME, PH_EXPECT_EQ: begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_err    = ERR_NO_VALUE;
        end
        PH_VAL_START, PH_VAL_PLAIN: begin
          phase_next      = PH_LINE_DONE;
          held_count_next = '0;
          res_valid       = name_seen;
          res_kind        = KIND_ENTRY;
        end
        PH_VAL_QUOTED: begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_err    = ERR_OPEN_QUOTE;
        end
        PH_LINE_DONE, PH_ERROR: phase_next = phase;
        default: phase_next = phase;
      endcase
      if (item.end_of_line && phase_next != PH_ERROR) begin
        phase_next          = PH_NAME_START;
        quote_byte_next     = '0;
        escape_pending_next = 1'b0;
        name_seen_next      = 1'b0;
        held_count_next     = '0;
      end
    end else begin
      unique case (phase)
        PH_NAME_START: begin
          priority if (is_ws(c)) begin
            phase_next = phase;
          end else if (c == CH_HASH) begin
            phase_next = PH_LINE_DONE;
          end else if (is_name_byte(c)) begin
            name_seen_next = 1'b1;
            phase_next     = PH_IN_NAME;
            res_valid      = 1'b1;
            res_kind       = KIND_NAME;
            res_char       = c;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_BAD_NAME_START;
          end
        end
        PH_IN_NAME: begin
          priority if (is_ws(c)) begin
            phase_next = PH_EXPECT_EQ;
          end else if (c == CH_EQUALS) begin
            phase_next = PH_VAL_START;
          end else if (is_name_byte(c)) begin
            res_valid = 1'b1;
            res_kind  = KIND_NAME;
            res_char  = c;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_BAD_NAME_CHAR;
          end
        end
        PH_EXPECT_EQ: begin
          priority if (c == CH_EQUALS) begin
            phase_next = PH_VAL_START;
          end else if (is_ws(c)) begin
            phase_next = phase;
          end else begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_NO_EQUALS;
          end
        end
        PH_VAL_START: begin
          priority if (c == CH_HASH) begin
            phase_next      = PH_LINE_DONE;
            held_count_next = '0;
            res_valid       = name_seen;
            res_kind        = KIND_ENTRY;
          end else if (is_ws(c)) begin
            phase_next = phase;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            quote_byte_next     = c;
            escape_pending_next = 1'b0;
            phase_next          = PH_VAL_QUOTED;
          end else begin
            phase_next      = PH_VAL_PLAIN;
            held_count_next = '0;
            res_valid       = 1'b1;
            res_kind        = KIND_VALUE;
            res_char        = c;
          end
        end
        PH_VAL_PLAIN: begin
          priority if (c == CH_HASH) begin
            phase_next      = PH_LINE_DONE;
            held_count_next = '0;
            res_valid       = name_seen;
            res_kind        = KIND_ENTRY;
          end else if (is_ws(c)) begin
            if (held_count >= CNT_W'(HOLD_DEPTH)) begin
              phase_next = PH_ERROR;
              res_valid  = 1'b1;
              res_kind   = KIND_ERROR;
              res_err    = ERR_WS_OVERFLOW;
            end else begin
              held_we         = 1'b1;
              held_count_next = held_count + CNT_W'(1);
            end
          end else begin
            // Held whitespace goes out ahead of this character.
            need_flush      = (held_count != '0);
            held_count_next = '0;
            res_valid       = 1'b1;
            res_kind        = KIND_VALUE;
            res_char        = c;
          end
        end
        PH_VAL_QUOTED: begin
          priority if (c == CH_HASH) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_OPEN_QUOTE;
          end else if (escape_pending) begin
            escape_pending_next = 1'b0;
            res_valid           = 1'b1;
            res_kind            = KIND_VALUE;
            res_char            = c;
          end else if (c == CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else if (c == quote_byte) begin
            phase_next      = PH_LINE_DONE;
            held_count_next = '0;
            res_valid       = name_seen;
            res_kind        = KIND_ENTRY;
          end else begin
            res_valid = 1'b1;
            res_kind  = KIND_VALUE;
            res_char  = c;
          end
        end
        PH_LINE_DONE, PH_ERROR: phase_next = phase;
        default: phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_NAME_START;
      quote_byte     <= '0;
      escape_pending <= 1'b0;
      name_seen      <= 1'b0;
      held_count     <= '0;
    end else if (cmd.commit) begin
      phase          <= phase_next;
      quote_byte     <= quote_byte_next;
      escape_pending <= escape_pending_next;
      name_seen      <= name_seen_next;
      held_count     <= held_count_next;
    end
  end

  // Held whitespace memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && held_we) held_space[held_count[IDX_W-1:0]] <= c;
    held_q <= held_space[flush_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      flush_idx <= '0;
    end else if (cmd.flush_put) begin
      flush_idx <= flush_idx + CNT_W'(1);
    end
  end

  assign out_free = !tok_valid || !tok_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (cmd.load_final || cmd.flush_put) begin
      tok_valid <= 1'b1;
    end else if (!tok_stall) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_put) begin
      tok_item.kind       <= KIND_VALUE;
      tok_item.out_char   <= held_q;
      tok_item.error_code <= '0;
      tok_item.last       <= 1'b0;
    end else if (cmd.load_final) begin
      tok_item.kind       <= res_kind;
      tok_item.out_char   <= res_char;
      tok_item.error_code <= res_err;
      tok_item.last       <= 1'b1;
    end
  end

  assign stat.need_flush = need_flush;
  assign stat.has_result = res_valid;
  assign stat.out_free   = out_free;
  assign stat.flush_done = (flush_idx + CNT_W'(1)) == held_count;

  `ASSERT_SAME(a_count_bound, 1'b1, held_count <= CNT_W'(HOLD_DEPTH),
               "held whitespace count beyond buffer depth")
  `ASSERT_SAME(a_load_needs_room, cmd.load_final || cmd.flush_put, out_free,
               "output register loaded while still occupied")
  `ASSERT_SAME(a_flush_in_range, cmd.flush_put, flush_idx < held_count,
               "released entry beyond held whitespace")
  `ASSERT_NEXT(a_sof_clears, cmd.commit && item.start_file,
               phase == PH_NAME_START && held_count == '0,
               "start of file did not clear the parse state")

endmodule

>>> bench/tb_ini_line_tokenizer.sv
// Testbench for ini_line_tokenizer: random and directed INI text with a
// bit-accurate tokenizer predictor and a scoreboard of expected tokens.
// Depends on ilt_pkg and the ini_line_tokenizer RTL only.
`timescale 1ns / 1ps

module tb_ini_line_tokenizer
  import ilt_pkg::*;
();

  localparam int HOLD = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_ITEMS = 30;

  typedef struct packed {
    phase_t               phase;
    logic [7:0]           quote;
    logic                 esc;
    logic                 named;
    logic [HOLD-1:0][7:0] held;
    logic [5:0]           held_cnt;
  } parser_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item = '0;
  logic       tok_valid;
  logic       tok_stall = 1'b0;
  tok_item_t  tok_item;

  byte_item_t byte_plan[$];
  tok_item_t  tokens_due[$];
  tok_item_t  scratch[$];
  parser_t    model = '0;
  parser_t    shadow = '0;
  int         plan_total = 0;
  int         bytes_taken = 0;
  int         tokens_seen = 0;
  int         mismatches = 0;
  int         kind_count[4] = '{0, 0, 0, 0};
  logic       hold_on = 1'b0;
  logic       quiet_tail;

  assign quiet_tail = (bytes_taken + TAIL_ITEMS >= plan_total);

  ini_line_tokenizer #(.HOLD_DEPTH(HOLD)) dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_item   (tok_item)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDER;
  endfunction

  function automatic void push_token(ref tok_item_t q[$], input logic [1:0] k,
                                     input logic [7:0] c);
    tok_item_t t;
    t = '0;
    t.kind = k;
    t.out_char = c;
    q.insert(q.size(), t);
  endfunction

  function automatic void raise_error(ref parser_t s, ref tok_item_t q[$],
                                      input logic [2:0] code);
    tok_item_t t;
    t = '0;
    t.kind = KIND_ERROR;
    t.error_code = code;
    q.insert(q.size(), t);
    s.phase = PH_ERROR;
  endfunction

  function automatic void close_entry(ref parser_t s, ref tok_item_t q[$]);
    s.phase = PH_LINE_DONE;
    s.held_cnt = '0;
    if (s.named) push_token(q, KIND_ENTRY, CH_NUL);
  endfunction

  // Advances the parser by one input item and appends the tokens it causes.
  function automatic void tokenize_step(ref parser_t s, input byte_item_t it,
                                        ref tok_item_t q[$]);
    int        n0;
    logic [7:0] c;
    tok_item_t t;
    n0 = q.size();
    c = it.ch;
    if (it.start_file) begin
      s = '0;
      return;
    end
    if (s.phase == PH_ERROR) return;
    if (it.end_of_line || c == CH_NUL) begin
      case (s.phase)
        PH_NAME_START: s.phase = PH_LINE_DONE;
        PH_IN_NAME, PH_EXPECT_EQ: raise_error(s, q, ERR_NO_VALUE);
        PH_VAL_START, PH_VAL_PLAIN: close_entry(s, q);
        PH_VAL_QUOTED: raise_error(s, q, ERR_OPEN_QUOTE);
        default: ;
      endcase
      // A real end of line starts the next line afresh unless it failed.
      if (it.end_of_line && s.phase != PH_ERROR) begin
        s.phase = PH_NAME_START;
        s.quote = '0;
        s.esc = 1'b0;
        s.named = 1'b0;
        s.held_cnt = '0;
      end
    end else begin
      case (s.phase)
        PH_NAME_START: begin
          if (is_blank(c)) ;
          else if (c == CH_HASH) s.phase = PH_LINE_DONE;
          else if (is_word(c)) begin
            s.named = 1'b1;
            s.phase = PH_IN_NAME;
            push_token(q, KIND_NAME, c);
          end else raise_error(s, q, ERR_BAD_NAME_START);
        end
        PH_IN_NAME: begin
          if (is_blank(c)) s.phase = PH_EXPECT_EQ;
          else if (c == CH_EQUALS) s.phase = PH_VAL_START;
          else if (is_word(c)) push_token(q, KIND_NAME, c);
          else raise_error(s, q, ERR_BAD_NAME_CHAR);
        end
        PH_EXPECT_EQ: begin
          if (c == CH_EQUALS) s.phase = PH_VAL_START;
          else if (!is_blank(c)) raise_error(s, q, ERR_NO_EQUALS);
        end
        PH_VAL_START: begin
          if (c == CH_HASH) close_entry(s, q);
          else if (is_blank(c)) ;
          else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            s.quote = c;
            s.esc = 1'b0;
            s.phase = PH_VAL_QUOTED;
          end else begin
            s.phase = PH_VAL_PLAIN;
            s.held_cnt = '0;
            push_token(q, KIND_VALUE, c);
          end
        end
        PH_VAL_PLAIN: begin
          if (c == CH_HASH) close_entry(s, q);
          else if (is_blank(c)) begin
            if (s.held_cnt >= HOLD) raise_error(s, q, ERR_WS_OVERFLOW);
            else begin
              s.held[s.held_cnt] = c;
              s.held_cnt = s.held_cnt + 1'b1;
            end
          end else begin
            // Held whitespace is inner whitespace after all: release it.
            for (int i = 0; i < s.held_cnt; i++) push_token(q, KIND_VALUE, s.held[i]);
            s.held_cnt = '0;
            push_token(q, KIND_VALUE, c);
          end
        end
        PH_VAL_QUOTED: begin
          if (c == CH_HASH) raise_error(s, q, ERR_OPEN_QUOTE);
          else if (s.esc) begin
            s.esc = 1'b0;
            push_token(q, KIND_VALUE, c);
          end else if (c == CH_BSLASH) s.esc = 1'b1;
          else if (c == s.quote) close_entry(s, q);
          else push_token(q, KIND_VALUE, c);
        end
        default: ;
      endcase
    end
    if (q.size() > n0) begin
      t = q.pop_back();
      t.last = 1'b1;
      q.insert(q.size(), t);
    end
  endfunction

  // ----------------------------------------------------------------- stimulus

  task automatic plan_item(input logic [7:0] c, input logic eol, input logic sof);
    byte_item_t it;
    it.ch = c;
    it.end_of_line = eol;
    it.start_file = sof;
    byte_plan.insert(byte_plan.size(), it);
    tokenize_step(shadow, it, scratch);
    scratch.delete();
  endtask

  task automatic plan_byte(input logic [7:0] c);
    plan_item(c, 1'b0, 1'b0);
  endtask

  task automatic plan_text(input string txt);
    for (int i = 0; i < txt.len(); i++) plan_byte(txt[i]);
  endtask

  task automatic plan_eol();
    plan_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic plan_sof();
    plan_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 3))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return 8'("a" + $urandom_range(0, 25));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? CH_SPACE : 8'(8 + r);
  endfunction

  // A byte that keeps an unquoted value going; a first byte may not open a quote.
  function automatic logic [7:0] plain_char(input logic first);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (is_blank(c) || c == CH_HASH ||
           (first && (c == CH_DQUOTE || c == CH_SQUOTE)))
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(input logic [7:0] qc);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_HASH || c == CH_BSLASH || c == qc) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic plan_line();
    int         pick;
    int         n;
    logic [7:0] qc;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      repeat ($urandom_range(0, 1)) plan_byte(blank_char());
      repeat ($urandom_range(1, 5)) plan_byte(name_char());
      repeat ($urandom_range(0, 2)) plan_byte(blank_char());
      plan_byte(CH_EQUALS);
      repeat ($urandom_range(0, 2)) plan_byte(blank_char());
      case ($urandom_range(0, 4))
        1, 2: begin
          plan_byte(plain_char(1'b1));
          repeat ($urandom_range(0, 5)) begin
            repeat ($urandom_range(0, 2)) plan_byte(blank_char());
            plan_byte(plain_char(1'b0));
          end
          repeat ($urandom_range(0, 3)) plan_byte(blank_char());
          if ($urandom_range(0, 3) == 0) begin
            plan_byte(CH_HASH);
            plan_byte(8'($urandom_range(0, 255)));
          end
        end
        3: begin
          qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          plan_byte(qc);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) begin
              plan_byte(CH_BSLASH);
              case ($urandom_range(0, 3))
                0: plan_byte(qc);
                1: plan_byte(CH_BSLASH);
                default: plan_byte(quoted_char(qc));
              endcase
            end else plan_byte(quoted_char(qc));
          end
          // Mostly closed; sometimes broken by a hash or left open.
          n = $urandom_range(0, 9);
          if (n == 0) plan_byte(CH_HASH);
          else if (n > 1) begin
            plan_byte(qc);
            repeat ($urandom_range(0, 2)) plan_byte(8'($urandom_range(0, 255)));
          end
        end
        4: begin
          // Long whitespace runs probe the hold buffer edge and overflow.
          plan_byte(plain_char(1'b1));
          repeat ($urandom_range(12, 18)) plan_byte(blank_char());
          plan_byte(plain_char(1'b0));
        end
        default: ;
      endcase
      if ($urandom_range(0, 6) == 0) begin
        plan_byte(CH_NUL);
        repeat ($urandom_range(0, 2)) plan_byte(8'($urandom_range(1, 255)));
      end
      plan_eol();
    end else if (pick < 70) begin
      repeat ($urandom_range(0, 2)) plan_byte(blank_char());
      if ($urandom_range(0, 1) == 1) begin
        plan_byte(CH_HASH);
        repeat ($urandom_range(0, 3)) plan_byte(8'($urandom_range(0, 255)));
      end
      plan_eol();
    end else if (pick < 93) begin
      case ($urandom_range(0, 2))
        0: begin
          if ($urandom_range(0, 1) == 1) plan_byte(name_char());
          repeat ($urandom_range(1, 4)) plan_byte(8'($urandom_range(0, 255)));
        end
        1: begin
          repeat ($urandom_range(1, 3)) plan_byte(name_char());
          plan_byte(blank_char());
          plan_byte(name_char());
        end
        default: repeat ($urandom_range(1, 3)) plan_byte(name_char());
      endcase
      plan_eol();
    end else plan_sof();
    // Usually recover from a sticky error; occasionally keep feeding it.
    if (shadow.phase == PH_ERROR && $urandom_range(0, 7) != 0) plan_sof();
  endtask

  initial begin
    plan_text("k=v");
    plan_eol();
    plan_text("#");
    plan_eol();
    plan_eol();
    plan_text("x");
    plan_eol();
    plan_sof();
    plan_text("q='a\\#");
    plan_sof();
    plan_text("z=");
    plan_byte(CH_NUL);
    plan_text("w");
    plan_eol();
    plan_byte(8'hFF);
    plan_eol();
    plan_item(8'h41, 1'b1, 1'b1);
    while (byte_plan.size() < 150) plan_line();
    plan_total = byte_plan.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != plan_total) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d input items and checked %0d tokens: %0d name, %0d value,",
             bytes_taken, tokens_seen, kind_count[0], kind_count[1]);
    $display("%0d entry ends and %0d errors, with one long output hold.",
             kind_count[2], kind_count[3]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ------------------------------------------------------------------- driver

  always @(posedge clk) begin
    logic took;
    int   send_gap;
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap = 0;
    end else begin
      took = byte_valid && !byte_stall;
      if (took) begin
        tokenize_step(model, byte_item, tokens_due);
        bytes_taken <= bytes_taken + 1;
      end
      // A new item is chosen only when nothing is being offered or the offered item was just taken.
      if (!byte_valid || took) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          byte_valid <= 1'b0;
        end else if (byte_plan.size() == 0) begin
          byte_valid <= 1'b0;
        end else if (!quiet_tail && !hold_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          byte_valid <= 1'b0;
        end else begin
          byte_item <= byte_plan.pop_front();
          byte_valid <= 1'b1;
        end
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(posedge clk) begin
    int   stall_left;
    logic held_once;
    if (rst) begin
      tok_stall <= 1'b0;
      stall_left = 0;
      held_once = 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      tok_stall <= 1'b1;
    end else if (!held_once && bytes_taken >= 60) begin
      // Long hold so the block backs up and stalls its input.
      held_once = 1'b1;
      hold_on <= 1'b1;
      stall_left = 59;
      tok_stall <= 1'b1;
    end else begin
      hold_on <= 1'b0;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        tok_stall <= 1'b1;
      end else begin
        tok_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  always @(posedge clk) begin
    tok_item_t want;
    logic      bad;
    if (!rst && tok_valid && !tok_stall) begin
      tokens_seen <= tokens_seen + 1;
      kind_count[tok_item.kind] <= kind_count[tok_item.kind] + 1;
      if (tokens_due.size() == 0) begin
        $display("%0t: token expected none, got kind %0d char %h code %0d", $time,
                 tok_item.kind, tok_item.out_char, tok_item.error_code);
        mismatches <= mismatches + 1;
      end else begin
        want = tokens_due.pop_front();
        bad = 1'b0;
        if (tok_item.kind !== want.kind) begin
          $display("%0t: kind expected %0d, got %0d", $time, want.kind, tok_item.kind);
          bad = 1'b1;
        end
        if (tok_item.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h, got %h", $time, want.out_char,
                   tok_item.out_char);
          bad = 1'b1;
        end
        if (tok_item.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                   tok_item.error_code);
          bad = 1'b1;
        end
        if (tok_item.last !== want.last) begin
          $display("%0t: last expected %0d, got %0d", $time, want.last, tok_item.last);
          bad = 1'b1;
        end
        if (bad) mismatches <= mismatches + 1;
      end
    end
  end

  // ----------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((byte_valid && !byte_stall) || (tok_valid && !tok_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d tokens still due", $time,
                 IDLE_LIMIT, tokens_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
